### hdl/fbpc_pkg.sv
`default_nettype none

package fbpc_pkg;

	// address space and table search limit
	localparam int ADDR_BITS      = 24;
	localparam int TABLE_ENTRIES  = 9;
	localparam int TABLE_DEPTH    = 16;
	localparam int SMALL_ENTRIES  = (TABLE_ENTRIES < 5) ? TABLE_ENTRIES : 5;
	localparam int LARGE_ENTRIES  = (TABLE_ENTRIES < 9) ? TABLE_ENTRIES : 9;
	localparam logic [23:0] OFFSET_MASK = 24'((25'd1 << ADDR_BITS) - 25'd1);

	// register map
	localparam int CFG_ADDR_BITS = 3;
	localparam logic CFG_PART_SELECT = 1'b0;
	localparam logic CFG_FLASH_SIZE  = 1'b1;
	localparam logic       PART_SELECT_RESET = 1'b1;
	localparam logic [24:0] FLASH_SIZE_RESET  = 25'h0800000;

	// operations
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_ENCODE = 1'b1;

	// result codes
	localparam logic [1:0] RC_SUCCESS = 2'd0;
	localparam logic [1:0] RC_INVALID = 2'd1;
	localparam logic [1:0] RC_DENIED  = 2'd2;

	// key bits: cmp, sec, tb, bp2..bp0
	localparam int KEY_CMP = 5;
	localparam int KEY_SEC = 4;
	localparam int KEY_TB  = 3;

	typedef struct packed {
		logic        operation;
		logic [7:0]  status1;
		logic [7:0]  status2;
		logic [23:0] offset;
		logic [24:0] length;
	} fbpc_req_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic [23:0] range_start;
		logic [24:0] range_len;
		logic [7:0]  new_status1;
		logic [7:0]  new_status2;
		logic [1:0]  wp_mode;
	} fbpc_rsp_t;

	typedef struct packed {
		logic [5:0]  care;
		logic [5:0]  value;
		logic [23:0] start;
		logic [24:0] len;
	} fbpc_entry_t;

	localparam fbpc_entry_t SMALL_TABLE [TABLE_DEPTH] = '{
		0: '{6'h07, 6'h00, 24'h000000, 25'h0000000},
		1: '{6'h0F, 6'h0B, 24'h000000, 25'h0040000},
		2: '{6'h0F, 6'h09, 24'h000000, 25'h0010000},
		3: '{6'h0F, 6'h0A, 24'h000000, 25'h0020000},
		4: '{6'h04, 6'h04, 24'h000000, 25'h0080000},
		default: '{6'h00, 6'h00, 24'h000000, 25'h0000000}
	};

	localparam fbpc_entry_t LARGE_TABLE [TABLE_DEPTH] = '{
		0: '{6'h27, 6'h00, 24'h000000, 25'h0000000},
		1: '{6'h3F, 6'h0E, 24'h000000, 25'h0400000},
		2: '{6'h3E, 6'h1C, 24'h000000, 25'h0008000},
		3: '{6'h3F, 6'h09, 24'h000000, 25'h0020000},
		4: '{6'h3F, 6'h0A, 24'h000000, 25'h0040000},
		5: '{6'h3F, 6'h0B, 24'h000000, 25'h0080000},
		6: '{6'h3F, 6'h0C, 24'h000000, 25'h0100000},
		7: '{6'h3F, 6'h0D, 24'h000000, 25'h0200000},
		8: '{6'h27, 6'h07, 24'h000000, 25'h0800000},
		default: '{6'h00, 6'h00, 24'h000000, 25'h0000000}
	};

endpackage

`default_nettype wire

### hdl/flash_block_protect_checker_unit.sv
`default_nettype none

// block-protect decoder and encoder for a serial nor flash. a request word
// (operation, both status bytes, offset, length) is taken on any cycle with
// start high; busy is tied low, so one word per clock is accepted forever.
// the response word appears on response for exactly one cycle with done high,
// once the word has gone through the input register and then through the
// table match into the output register. the receiver cannot
// stall and nothing is queued, so there is no back pressure at all. check
// (operation 0) decodes the cmp/sec/tb/bp bits against the selected part's
// protect table, first match wins, and reports access denied when the
// region overlaps the protected range. encode (operation 1) finds the entry
// whose range equals the region and returns the status bytes that select
// it, refused with access denied while srp0/srp1 show write protection.
// part_select (0x0) and flash_size (0x4) sit on the apb port and should
// only be changed with no word in flight.
module flash_block_protect_checker_unit
	import fbpc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// request channel
	input  wire logic                     start,
	output logic                          busy,
	input  wire fbpc_req_t                request,
	// response channel
	output logic                          done,
	output fbpc_rsp_t                     response,
	// apb configuration port
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [CFG_ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]              pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// configuration registers
	logic        part_select_q;
	logic [24:0] flash_size_q;
	logic        cfg_write;

	// input stage
	logic      req_valid_s1;
	fbpc_req_t req_s1;

	// datapath
	logic [7:0]  s2_eff;
	logic [23:0] off;
	logic [25:0] end_sum;
	logic        in_range;
	logic [5:0]  key;
	logic [4:0]  entry_count;
	logic        dec_hit;
	fbpc_entry_t dec_entry;
	logic        enc_hit;
	fbpc_entry_t enc_entry;
	fbpc_entry_t cur_entry;
	logic [25:0] ent_end;
	logic [25:0] ovl_lo;
	logic [25:0] ovl_hi;
	logic [1:0]  wp;
	fbpc_rsp_t   rsp_d;

	assign pready    = 1'b1;
	assign busy      = 1'b0;
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_select_q <= PART_SELECT_RESET;
			flash_size_q  <= FLASH_SIZE_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				CFG_PART_SELECT: part_select_q <= pwdata[0];
				CFG_FLASH_SIZE:  flash_size_q  <= pwdata[24:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			CFG_PART_SELECT: prdata = {31'd0, part_select_q};
			CFG_FLASH_SIZE:  prdata = {7'd0, flash_size_q};
			default:         prdata = 32'd0;
		endcase
	end

	// input register: a word may land every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else begin
			req_valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start & ~busy) begin
			req_s1 <= request;
		end
	end

	// small part has no status register 2
	assign s2_eff   = part_select_q ? req_s1.status2 : 8'd0;
	assign off      = req_s1.offset & OFFSET_MASK;
	// end of region, kept one bit wider so it never wraps
	assign end_sum  = {2'b00, off} + {1'b0, req_s1.length};
	assign in_range = end_sum <= {1'b0, flash_size_q};
	assign key      = {s2_eff[6], req_s1.status1[6], req_s1.status1[5],
		req_s1.status1[4:2]};
	// srp1 is status2 bit 0, srp0 is status1 bit 7
	assign wp       = {s2_eff[0], req_s1.status1[7]};
	assign entry_count = part_select_q ? 5'(LARGE_ENTRIES) : 5'(SMALL_ENTRIES);

	// priority search over the part's table, first match wins
	always_comb begin
		dec_hit   = 1'b0;
		dec_entry = '0;
		enc_hit   = 1'b0;
		enc_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			cur_entry = part_select_q ? LARGE_TABLE[i] : SMALL_TABLE[i];
			if (5'(i) < entry_count) begin
				if (!dec_hit && ((key & cur_entry.care) == cur_entry.value)) begin
					dec_hit   = 1'b1;
					dec_entry = cur_entry;
				end
				if (!enc_hit && (cur_entry.start == off)
					&& (cur_entry.len == req_s1.length)) begin
					enc_hit   = 1'b1;
					enc_entry = cur_entry;
				end
			end
		end
	end

	// overlap of [off, end) with [start, start + len)
	assign ent_end = {2'b00, dec_entry.start} + {1'b0, dec_entry.len};
	assign ovl_lo  = (dec_entry.start > off) ? {2'b00, dec_entry.start} : {2'b00, off};
	assign ovl_hi  = (ent_end < end_sum) ? ent_end : end_sum;

	always_comb begin
		rsp_d             = '0;
		rsp_d.result_code = RC_INVALID;
		rsp_d.wp_mode     = wp;
		if (in_range) begin
			if (req_s1.operation == OP_CHECK) begin
				if (dec_hit) begin
					rsp_d.range_start = dec_entry.start;
					rsp_d.range_len   = dec_entry.len;
					if (ovl_lo < ovl_hi) begin
						rsp_d.result_code = RC_DENIED;
					end else begin
						rsp_d.result_code = RC_SUCCESS;
					end
				end
			end else if (!((off != 24'd0) && (req_s1.length == 25'd0))) begin
				if (enc_hit) begin
					rsp_d.range_start = enc_entry.start;
					rsp_d.range_len   = enc_entry.len;
					if (wp != 2'd0) begin
						rsp_d.result_code = RC_DENIED;
					end else begin
						rsp_d.result_code = RC_SUCCESS;
						// don't-care bits are zero in the table value
						rsp_d.new_status1 = {1'b0, enc_entry.value[KEY_SEC],
							enc_entry.value[KEY_TB], enc_entry.value[2:0], 2'b00};
						rsp_d.new_status2 = {1'b0, enc_entry.value[KEY_CMP], 6'd0};
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid_s1) begin
			response <= rsp_d;
		end
	end

endmodule

`default_nettype wire

### hdl/fbpc_checker.sv
`default_nettype none

module fbpc_checker
	import fbpc_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      start,
	input wire logic      busy,
	input wire logic      done,
	input wire fbpc_rsp_t response
);

	// every accepted word gives exactly one response
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted word lost");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start && !busy) |=> !done)
		else $error("response without request");

	// new status bytes only on a successful encode
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && response.result_code != RC_SUCCESS) |->
			(response.new_status1 == 8'd0 && response.new_status2 == 8'd0))
		else $error("status bytes on failed word");

	// an invalid word carries no range and the code stays in range
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (response.result_code != 2'd3 &&
			(response.result_code != RC_INVALID || response.range_len == 25'd0)))
		else $error("bad result code or range");

endmodule

bind flash_block_protect_checker_unit fbpc_checker u_fbpc_checker (.*);

`default_nettype wire
